[src/assert_macros.svh]
// Assertion macros for the subscription publish engine RTL, used by spe_datapath.
// Each macro expects clk and arst_n to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SPE_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[src/spe_pkg.sv]
// Types, codes and helper functions for the subscription publish engine.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package spe_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [2:0] CFG_LIFETIME  = 3'd0;
	localparam logic [2:0] CFG_KEEPALIVE = 3'd1;
	localparam logic [2:0] CFG_PER_PUB   = 3'd2;
	localparam logic [2:0] CFG_PUB_EN    = 3'd3;
	localparam logic [2:0] CFG_RETAIN_EN = 3'd4;

	typedef enum logic [3:0] {
		ACT_WAIT      = 4'd0,
		ACT_LATE      = 4'd1,
		ACT_KEEPALIVE = 4'd2,
		ACT_DATA      = 4'd3,
		ACT_EXPIRED   = 4'd4,
		ACT_REMOVED   = 4'd5,
		ACT_ACK_GOOD  = 4'd6,
		ACT_ACK_UNK   = 4'd7,
		ACT_STARTED   = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

	// Which logical store position feeds the address unit.
	typedef enum logic [1:0] {
		IDX_PTR,
		IDX_NEXT,
		IDX_COUNT
	} idx_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     exec;
		logic     mem_rd;
		logic     scan_miss;
		logic     scan_hit;
		logic     shift_wr;
		logic     shrink;
		logic     load_out;
		idx_sel_t idx_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic match;
		logic last;
		logic out_free;
	} ctrl_sts_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

[src/spe_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module spe_ram #(
	parameter int W = 32,
	parameter int D = 256,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata_q
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[src/spe_datapath.sv]
// Datapath: configuration, subscription counters, retained sequence store
// (circular buffer in spe_ram) and result/output registers. Uses spe_pkg.
`default_nettype none
`include "assert_macros.svh"
module spe_datapath #(
	parameter int RETAIN_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic [1:0]         cmd,
	input  wire logic               request_ready,
	input  wire logic               channel_open,
	input  wire logic [15:0]        queued_count,
	input  wire logic [31:0]        ack_number,
	input  wire spe_pkg::ctrl_cmd_t ctl,
	output spe_pkg::ctrl_sts_t      sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              action,
	output logic [31:0]             sent_sequence,
	output logic [15:0]             sent_count,
	output logic                    more_pending,
	output logic [8:0]              retained_count,
	output logic                    late_flag
);

	localparam int AW = (RETAIN_DEPTH > 1) ? $clog2(RETAIN_DEPTH) : 1;
	localparam int CW = $clog2(RETAIN_DEPTH + 1);

	// configuration
	logic [31:0] lt_limit_q;
	logic [31:0] ka_limit_q;
	logic [15:0] ppl_q;
	logic        pub_en_q;
	logic        ret_en_q;

	// latched transaction
	logic [1:0]  cmd_q;
	logic        req_q;
	logic        chan_q;
	logic [15:0] queued_q;
	logic [31:0] ack_q;

	// subscription state
	logic [31:0]   lt_cnt_q;
	logic [31:0]   ka_cnt_q;
	logic [31:0]   next_seq_q;
	logic          late_q;
	logic          removed_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] ptr_q;

	// result of the current transaction
	spe_pkg::action_t res_action_q;
	logic [31:0]      res_seq_q;
	logic [15:0]      res_cnt_q;
	logic             res_more_q;

	logic          out_valid_q;
	logic [3:0]    action_q;
	logic [31:0]   sent_seq_q;
	logic [15:0]   sent_cnt_q;
	logic          more_q;
	logic [8:0]    ret_cnt_q;
	logic          late_out_q;

	// store addressing
	logic [CW-1:0] ptr_next;
	logic [CW-1:0] lidx;
	logic [CW:0]   psum;
	logic [CW:0]   pwrap;
	logic [AW-1:0] paddr;
	logic          full;
	logic [AW-1:0] head_inc;

	logic          mem_we;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;

	// tick evaluation
	logic [31:0]      t_lt;
	logic             t_expired;
	logic [15:0]      t_n;
	logic [15:0]      t_left;
	logic [31:0]      t_ka_inc;
	logic [31:0]      t_ka;
	logic             t_go;
	logic             t_send;
	logic             t_retain;
	logic [31:0]      t_seq_inc;
	spe_pkg::action_t t_action;

	assign ptr_next = ptr_q + CW'(1);
	assign full     = (count_q == CW'(RETAIN_DEPTH));
	assign head_inc = (head_q == AW'(RETAIN_DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		unique case (ctl.idx_sel)
			spe_pkg::IDX_PTR:   lidx = ptr_q;
			spe_pkg::IDX_NEXT:  lidx = ptr_next;
			spe_pkg::IDX_COUNT: lidx = count_q;
			default:            lidx = ptr_q;
		endcase
		psum  = (CW+1)'(head_q) + (CW+1)'(lidx);
		pwrap = (psum >= (CW+1)'(RETAIN_DEPTH)) ? psum - (CW+1)'(RETAIN_DEPTH) : psum;
		paddr = pwrap[AW-1:0];
	end

	always_comb begin
		t_lt      = req_q ? 32'd0 : spe_pkg::sat_inc32(lt_cnt_q);
		t_expired = !req_q && (t_lt > lt_limit_q);
		t_n       = pub_en_q ? queued_q : 16'd0;
		if (ppl_q != 16'd0 && t_n > ppl_q) begin
			t_n = ppl_q;
		end
		t_left    = queued_q - t_n;
		t_ka_inc  = spe_pkg::sat_inc32(ka_cnt_q);
		t_go      = (t_n != 16'd0) || !(t_ka_inc < ka_limit_q);
		t_send    = t_go && req_q && chan_q;
		t_retain  = t_send && (t_n != 16'd0) && ret_en_q;
		t_seq_inc = (next_seq_q == 32'hFFFF_FFFF) ? 32'd1 : next_seq_q + 32'd1;
		t_ka      = ka_cnt_q;
		if (t_n == 16'd0) begin
			t_ka = t_ka_inc;
		end
		if (t_send) begin
			t_ka = 32'd0;
		end
		priority if (t_expired) begin
			t_action = spe_pkg::ACT_EXPIRED;
		end else if (!t_go) begin
			t_action = spe_pkg::ACT_WAIT;
		end else if (!t_send) begin
			t_action = spe_pkg::ACT_LATE;
		end else if (t_n != 16'd0) begin
			t_action = spe_pkg::ACT_DATA;
		end else begin
			t_action = spe_pkg::ACT_KEEPALIVE;
		end
	end

	wire exec_tick = ctl.exec && !removed_q && (cmd_q == spe_pkg::CMD_TICK);

	assign mem_we    = (exec_tick && !t_expired && t_retain) || ctl.shift_wr;
	assign mem_wdata = ctl.shift_wr ? mem_rdata : next_seq_q;

	spe_ram #(.W(32), .D(RETAIN_DEPTH)) u_store (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (paddr),
		.wdata  (mem_wdata),
		.re     (ctl.mem_rd),
		.raddr  (paddr),
		.rdata_q(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_limit_q <= 32'd3;
			ka_limit_q <= 32'd1;
			ppl_q      <= 16'd0;
			pub_en_q   <= 1'b0;
			ret_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spe_pkg::CFG_LIFETIME:  lt_limit_q <= cfg_data;
				spe_pkg::CFG_KEEPALIVE: ka_limit_q <= cfg_data;
				spe_pkg::CFG_PER_PUB:   ppl_q      <= cfg_data[15:0];
				spe_pkg::CFG_PUB_EN:    pub_en_q   <= cfg_data[0];
				spe_pkg::CFG_RETAIN_EN: ret_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q    <= cmd;
			req_q    <= request_ready;
			chan_q   <= channel_open;
			queued_q <= queued_count;
			ack_q    <= ack_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_cnt_q     <= '0;
			ka_cnt_q     <= '0;
			next_seq_q   <= 32'd1;
			late_q       <= 1'b0;
			removed_q    <= 1'b0;
			count_q      <= '0;
			head_q       <= '0;
			ptr_q        <= '0;
			res_action_q <= spe_pkg::ACT_WAIT;
			res_seq_q    <= '0;
			res_cnt_q    <= '0;
			res_more_q   <= 1'b0;
		end else begin
			if (ctl.exec) begin
				ptr_q      <= '0;
				res_seq_q  <= '0;
				res_cnt_q  <= '0;
				res_more_q <= 1'b0;
				if (removed_q) begin
					res_action_q <= spe_pkg::ACT_REMOVED;
				end else begin
					unique case (cmd_q)
						spe_pkg::CMD_ACK: res_action_q <= spe_pkg::ACT_ACK_UNK;
						spe_pkg::CMD_START: begin
							ka_cnt_q     <= ka_limit_q;
							res_action_q <= spe_pkg::ACT_STARTED;
						end
						spe_pkg::CMD_TICK: begin
							lt_cnt_q     <= t_lt;
							res_action_q <= t_action;
							if (t_expired) begin
								removed_q <= 1'b1;
								count_q   <= '0;
							end else begin
								ka_cnt_q <= t_ka;
								if (t_go && !t_send) begin
									late_q <= 1'b1;
								end
								if (t_send) begin
									res_seq_q  <= next_seq_q;
									res_cnt_q  <= t_n;
									res_more_q <= (t_left != 16'd0);
									if (t_left == 16'd0) begin
										late_q <= 1'b0;
									end
									if (t_n != 16'd0) begin
										next_seq_q <= t_seq_inc;
									end
								end
								// when full, the new number overwrites the oldest
								if (t_retain) begin
									if (full) begin
										head_q <= head_inc;
									end else begin
										count_q <= count_q + CW'(1);
									end
								end
							end
						end
						default: res_action_q <= spe_pkg::ACT_WAIT;
					endcase
				end
			end
			if (ctl.scan_miss || ctl.shift_wr) begin
				ptr_q <= ptr_next;
			end
			if (ctl.scan_hit) begin
				res_action_q <= spe_pkg::ACT_ACK_GOOD;
			end
			if (ctl.shrink) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			action_q   <= res_action_q;
			sent_seq_q <= res_seq_q;
			sent_cnt_q <= res_cnt_q;
			more_q     <= res_more_q;
			ret_cnt_q  <= 9'(count_q);
			late_out_q <= late_q;
		end
	end

	assign sts.need_scan = (cmd_q == spe_pkg::CMD_ACK) && !removed_q && (count_q != '0);
	assign sts.match     = (mem_rdata == ack_q);
	assign sts.last      = (ptr_next == count_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign sent_sequence  = sent_seq_q;
	assign sent_count     = sent_cnt_q;
	assign more_pending   = more_q;
	assign retained_count = ret_cnt_q;
	assign late_flag      = late_out_q;

	`SPE_ASSERT(a_count_bound, count_q <= CW'(RETAIN_DEPTH), "retained count above depth")
	`SPE_ASSERT(a_head_bound, head_q <= AW'(RETAIN_DEPTH - 1), "store head out of range")
	`SPE_ASSERT(a_shift_inside, ctl.shift_wr |-> (ptr_next < count_q), "shift beyond valid entries")
	`SPE_ASSERT(a_load_out, ctl.load_out |=> out_valid_q, "result lost after load")

endmodule
`default_nettype wire

[src/spe_ctrl.sv]
// Controller state machine: sequences execute, store scan and compaction.
// Uses spe_pkg; drives spe_datapath through ctrl_cmd_t / ctrl_sts_t.
`default_nettype none
module spe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire spe_pkg::ctrl_sts_t sts,
	output spe_pkg::ctrl_cmd_t      ctl
);

	spe_pkg::state_t state_q;
	spe_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.idx_sel = spe_pkg::IDX_PTR;
		in_ready    = 1'b0;
		unique case (state_q)
			spe_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
				if (in_valid) begin
					state_d = spe_pkg::ST_EXEC;
				end
			end
			spe_pkg::ST_EXEC: begin
				ctl.exec    = 1'b1;
				ctl.idx_sel = spe_pkg::IDX_COUNT;
				state_d     = sts.need_scan ? spe_pkg::ST_SCAN_RD : spe_pkg::ST_DONE;
			end
			spe_pkg::ST_SCAN_RD: begin
				ctl.mem_rd = 1'b1;
				state_d    = spe_pkg::ST_SCAN_CMP;
			end
			spe_pkg::ST_SCAN_CMP: begin
				priority if (sts.match) begin
					ctl.scan_hit = 1'b1;
					state_d      = spe_pkg::ST_SHIFT_RD;
				end else if (sts.last) begin
					state_d = spe_pkg::ST_DONE;
				end else begin
					ctl.scan_miss = 1'b1;
					state_d       = spe_pkg::ST_SCAN_RD;
				end
			end
			spe_pkg::ST_SHIFT_RD: begin
				// close the gap: move each newer entry down by one
				if (sts.last) begin
					ctl.shrink = 1'b1;
					state_d    = spe_pkg::ST_DONE;
				end else begin
					ctl.mem_rd  = 1'b1;
					ctl.idx_sel = spe_pkg::IDX_NEXT;
					state_d     = spe_pkg::ST_SHIFT_WR;
				end
			end
			spe_pkg::ST_SHIFT_WR: begin
				ctl.shift_wr = 1'b1;
				state_d      = spe_pkg::ST_SHIFT_RD;
			end
			spe_pkg::ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = spe_pkg::ST_IDLE;
				end
			end
			default: state_d = spe_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[src/subscription_publish_engine_core.sv]
// Top level of the subscription publish engine.
// Instantiates spe_ctrl and spe_datapath; uses spe_pkg.
`default_nettype none
// One transaction at a time. A publish tick or a start goes from acceptance
// to a loaded result through the accept, execute and result register steps;
// the last waits until the output register is free. An acknowledge scans the
// retained store from the oldest entry, reading then comparing each entry
// examined, then compacts the store by reading and writing each newer entry
// plus one final step, since the single store RAM reads or writes one entry
// per cycle with registered read data. The result register lets the next
// transaction be accepted and executed while a result waits. Configuration
// writes are accepted every cycle; no clearing pass after reset.
module subscription_publish_engine_core #(
	parameter int RETAIN_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic        request_ready,
	input  wire logic        channel_open,
	input  wire logic [15:0] queued_count,
	input  wire logic [31:0] ack_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       action,
	output logic [31:0]      sent_sequence,
	output logic [15:0]      sent_count,
	output logic             more_pending,
	output logic [8:0]       retained_count,
	output logic             late_flag
);

	spe_pkg::ctrl_cmd_t ctl;
	spe_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	spe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.ctl     (ctl)
	);

	spe_datapath #(.RETAIN_DEPTH(RETAIN_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.request_ready (request_ready),
		.channel_open  (channel_open),
		.queued_count  (queued_count),
		.ack_number    (ack_number),
		.ctl           (ctl),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.sent_sequence (sent_sequence),
		.sent_count    (sent_count),
		.more_pending  (more_pending),
		.retained_count(retained_count),
		.late_flag     (late_flag)
	);

endmodule
`default_nettype wire
